// ===== hdl/cpu65_pkg.sv =====
// Shared types, constants and decode function for the 65C02-subset core.
`timescale 1ns / 1ps
package cpu65_pkg;

	localparam logic [15:0] STACK_PAGE = 16'h0100;
	localparam logic [15:0] VEC_RESET  = 16'hFFFC;
	localparam logic [15:0] VEC_BRK    = 16'hFFFE;
	localparam logic [7:0]  F_PUSH     = 8'h30;
	localparam int          F_C        = 0;
	localparam int          F_I        = 2;
	localparam int          F_D        = 3;
	localparam int          F_V        = 6;

	localparam logic [3:0] STEP_RESET_LO = 4'd13;
	localparam logic [3:0] STEP_RESET_HI = 4'd14;
	localparam logic [3:0] STEP_RESET_GO = 4'd15;

	typedef enum logic [1:0] {
		BUS_READ  = 2'd0,
		BUS_WRITE = 2'd1,
		BUS_IDLE  = 2'd2
	} bus_kind_t;

	typedef enum logic [3:0] {
		M_IMM, M_ZP, M_ZPX, M_ABS, M_ABSX, M_ABSY, M_INDX, M_INDY, M_ZIND, M_ABSX_FLAT
	} mode_t;

	typedef enum logic [3:0] {
		C_ALU, C_LDX, C_NOPL, C_RMW, C_IMPL, C_PUSH, C_PULL, C_JMP, C_JIND,
		C_JSR, C_RTS, C_BRK, C_RTI, C_N5C, C_NOP1
	} op_class_t;

	typedef struct packed {
		op_class_t cls;
		mode_t     mode;
	} dec_t;

	typedef struct packed {
		logic [15:0] pc;
		logic [7:0]  sp;
		logic [7:0]  a;
		logic [7:0]  x;
		logic [7:0]  y;
		logic [7:0]  p;
		logic [7:0]  op;
		logic [3:0]  step;
		logic [15:0] ea;
		logic [7:0]  dl;
	} cpu_state_t;

	typedef struct packed {
		logic [15:0] addr;
		logic [7:0]  wdata;
		bus_kind_t   kind;
		logic        fetch;
	} bus_req_t;

	function automatic logic [7:0] set_zn(logic [7:0] p, logic [7:0] v);
		return {v[7], p[6:2], (v == 8'd0), p[0]};
	endfunction

	function automatic dec_t decode(logic [7:0] op);
		dec_t r;
		logic hit;
		r.cls  = C_NOP1;
		r.mode = M_IMM;
		hit    = 1'b1;
		case (op[6:0])
			7'h69: r.mode = M_IMM;
			7'h65: r.mode = M_ZP;
			7'h75: r.mode = M_ZPX;
			7'h6D: r.mode = M_ABS;
			7'h7D: r.mode = M_ABSX;
			7'h79: r.mode = M_ABSY;
			7'h61: r.mode = M_INDX;
			7'h71: r.mode = M_INDY;
			7'h72: r.mode = M_ZIND;
			default: hit = 1'b0;
		endcase
		if (hit) begin
			r.cls = C_ALU;
		end else begin
			case (op)
				8'hE6, 8'hC6: begin r.cls = C_RMW; r.mode = M_ZP; end
				8'hF6, 8'hD6: begin r.cls = C_RMW; r.mode = M_ZPX; end
				8'hEE, 8'hCE: begin r.cls = C_RMW; r.mode = M_ABS; end
				8'hFE, 8'hDE: begin r.cls = C_RMW; r.mode = M_ABSX; end
				8'hEA, 8'hAA, 8'hA8, 8'hBA, 8'h8A, 8'h9A, 8'h98, 8'hE8, 8'hC8,
				8'hCA, 8'h88, 8'h18, 8'hD8, 8'h58, 8'hB8, 8'h38, 8'hF8, 8'h78:
					r.cls = C_IMPL;
				8'hA2: r.cls = C_LDX;
				8'h02, 8'h22, 8'h42, 8'h62, 8'h82, 8'hC2, 8'hE2: r.cls = C_NOPL;
				8'h44: begin r.cls = C_NOPL; r.mode = M_ZP; end
				8'h54, 8'hD4, 8'hF4: begin r.cls = C_NOPL; r.mode = M_ZPX; end
				8'hDC, 8'hFC: begin r.cls = C_NOPL; r.mode = M_ABSX_FLAT; end
				8'h5C: r.cls = C_N5C;
				8'h48, 8'h08: r.cls = C_PUSH;
				8'h68, 8'h28: r.cls = C_PULL;
				8'h4C: r.cls = C_JMP;
				8'h6C, 8'h7C: r.cls = C_JIND;
				8'h20: r.cls = C_JSR;
				8'h60: r.cls = C_RTS;
				8'h00: r.cls = C_BRK;
				8'h40: r.cls = C_RTI;
				default: r.cls = C_NOP1;
			endcase
		end
		return r;
	endfunction

endpackage

// ===== hdl/cpu65_exec.sv =====
// Single-tick next-state and bus request logic of the 65C02-subset core.
`timescale 1ns / 1ps
module cpu65_exec (
	input  cpu65_pkg::cpu_state_t cur,
	input  logic [7:0]            d,
	output cpu65_pkg::cpu_state_t nxt,
	output cpu65_pkg::bus_req_t   req
);

	cpu65_pkg::cpu_state_t n;
	cpu65_pkg::dec_t       dec;
	logic [3:0]            k;
	logic [3:0]            nstep;
	logic                  fin;
	logic                  ld_done;
	logic [15:0]           base;
	logic [15:0]           eidx;
	logic [7:0]            idx;
	logic [3:0]            skip;
	logic [3:0]            wr;
	logic [7:0]            v;
	logic [7:0]            b;
	logic [8:0]            sum;
	logic [7:0]            r;

	always_comb begin
		n       = cur;
		k       = cur.step;
		nstep   = cur.step + 4'd1;
		fin     = 1'b0;
		ld_done = 1'b0;
		req     = '{addr: 16'd0, wdata: 8'd0, kind: cpu65_pkg::BUS_READ, fetch: 1'b0};
		dec     = cpu65_pkg::decode(cur.op);
		base    = 16'd0;
		eidx    = 16'd0;
		idx     = 8'd0;
		skip    = 4'd0;
		wr      = 4'd0;
		v       = 8'd0;
		b       = 8'd0;
		sum     = 9'd0;
		r       = 8'd0;
		if (k == cpu65_pkg::STEP_RESET_LO) begin
			req.addr = cpu65_pkg::VEC_RESET;
		end else if (k == cpu65_pkg::STEP_RESET_HI) begin
			n.dl     = d;
			req.addr = cpu65_pkg::VEC_RESET + 16'd1;
		end else if (k == cpu65_pkg::STEP_RESET_GO) begin
			n.pc = {d, cur.dl};
			fin  = 1'b1;
		end else begin
			if (k <= 4'd1) begin
				k     = 4'd1;
				n.op  = d;
				nstep = 4'd2;
				dec   = cpu65_pkg::decode(d);
			end
			case (dec.cls)
				cpu65_pkg::C_ALU, cpu65_pkg::C_LDX, cpu65_pkg::C_NOPL: begin
					if (k == 4'd1) begin
						req.addr = n.pc;
						if (dec.mode != cpu65_pkg::M_INDY) n.pc = n.pc + 16'd1;
					end else begin
						case (dec.mode)
							cpu65_pkg::M_IMM: ld_done = 1'b1;
							cpu65_pkg::M_ZP: begin
								if (k == 4'd2) begin
									n.ea = {8'd0, d}; req.addr = n.ea;
								end else ld_done = 1'b1;
							end
							cpu65_pkg::M_ZPX: begin
								if (k == 4'd2) begin
									n.ea = {8'd0, d}; req.addr = n.ea;
								end else if (k == 4'd3) begin
									n.ea = {8'd0, n.ea[7:0] + n.x}; req.addr = n.ea;
								end else ld_done = 1'b1;
							end
							cpu65_pkg::M_ABS: begin
								if (k == 4'd2) begin
									n.dl = d; req.addr = n.pc; n.pc = n.pc + 16'd1;
								end else if (k == 4'd3) begin
									n.ea = {d, n.dl}; req.addr = n.ea;
								end else ld_done = 1'b1;
							end
							cpu65_pkg::M_ABSX, cpu65_pkg::M_ABSY: begin
								if (k == 4'd2) begin
									n.dl = d; req.addr = n.pc;
								end else if (k == 4'd3) begin
									base = {d, n.dl};
									idx  = (dec.mode == cpu65_pkg::M_ABSX) ? n.x : n.y;
									skip = 4'd5;
									eidx = base + {8'd0, idx};
									n.ea = eidx;
									if (eidx[15:8] != base[15:8]) req.addr = n.pc;
									else begin
										req.addr = eidx; nstep = skip;
									end
									n.pc = n.pc + 16'd1;
								end else if (k == 4'd4) begin
									req.addr = n.ea;
								end else ld_done = 1'b1;
							end
							cpu65_pkg::M_ABSX_FLAT: begin
								if (k == 4'd2) begin
									n.dl = d; req.addr = n.pc;
								end else if (k == 4'd3) begin
									n.ea = {d, n.dl} + {8'd0, n.x};
									n.pc = n.pc + 16'd1;
									req.addr = n.ea;
								end else ld_done = 1'b1;
							end
							cpu65_pkg::M_INDX: begin
								if (k == 4'd2) begin
									n.ea = {8'd0, d}; req.addr = n.ea;
								end else if (k == 4'd3) begin
									n.ea = {8'd0, n.ea[7:0] + n.x}; req.addr = n.ea;
								end else if (k == 4'd4) begin
									n.dl = d; req.addr = {8'd0, n.ea[7:0] + 8'd1};
								end else if (k == 4'd5) begin
									n.ea = {d, n.dl}; req.addr = n.ea;
								end else ld_done = 1'b1;
							end
							cpu65_pkg::M_INDY: begin
								if (k == 4'd2) begin
									n.ea = {8'd0, d}; req.addr = n.ea;
								end else if (k == 4'd3) begin
									n.dl = d; req.addr = {8'd0, n.ea[7:0] + 8'd1};
								end else if (k == 4'd4) begin
									base = {d, n.dl};
									eidx = base + {8'd0, n.y};
									n.ea = eidx;
									if (eidx[15:8] != base[15:8]) req.addr = n.pc;
									else begin
										req.addr = eidx; nstep = 4'd6;
									end
									n.pc = n.pc + 16'd1;
								end else if (k == 4'd5) begin
									req.addr = n.ea;
								end else ld_done = 1'b1;
							end
							default: begin
								if (k == 4'd2) begin
									n.ea = {8'd0, d}; req.addr = n.ea;
								end else if (k == 4'd3) begin
									n.dl = d; req.addr = {8'd0, n.ea[7:0] + 8'd1};
								end else if (k == 4'd4) begin
									n.ea = {d, n.dl}; req.addr = n.ea;
								end else ld_done = 1'b1;
							end
						endcase
					end
					if (ld_done) begin
						fin = 1'b1;
						if (dec.cls == cpu65_pkg::C_ALU) begin
							b   = n.op[7] ? ~d : d;
							sum = {1'b0, n.a} + {1'b0, b} + {8'd0, n.p[cpu65_pkg::F_C]};
							r   = sum[7:0];
							n.p = cpu65_pkg::set_zn(n.p, r);
							n.p[cpu65_pkg::F_C] = sum[8];
							n.p[cpu65_pkg::F_V] = (n.a[7] ^ r[7]) & (b[7] ^ r[7]);
							n.a = r;
						end else if (dec.cls == cpu65_pkg::C_LDX) begin
							n.x = d;
							n.p = cpu65_pkg::set_zn(n.p, d);
						end
					end
				end
				cpu65_pkg::C_RMW: begin
					wr = (dec.mode == cpu65_pkg::M_ZP) ? 4'd4 :
					     (dec.mode == cpu65_pkg::M_ABSX) ? 4'd6 : 4'd5;
					if (k == wr) begin
						v = n.op[5] ? d + 8'd1 : d - 8'd1;
						n.p = cpu65_pkg::set_zn(n.p, v);
						req.addr  = n.ea;
						req.wdata = v;
						req.kind  = cpu65_pkg::BUS_WRITE;
					end else if (k > wr) begin
						fin = 1'b1;
					end else if (k == 4'd1) begin
						req.addr = n.pc; n.pc = n.pc + 16'd1;
					end else if (dec.mode == cpu65_pkg::M_ZP || dec.mode == cpu65_pkg::M_ZPX) begin
						if (k == 4'd2) begin
							n.ea = {8'd0, d}; req.addr = n.ea;
						end else if (k == 4'd3) begin
							req.addr = n.ea;
						end else begin
							n.ea = {8'd0, n.ea[7:0] + n.x}; req.addr = n.ea;
						end
					end else if (k == 4'd2) begin
						n.dl = d; req.addr = n.pc; n.pc = n.pc + 16'd1;
					end else if (k == 4'd3) begin
						n.ea = {d, n.dl}; req.addr = n.ea;
					end else if (dec.mode == cpu65_pkg::M_ABS) begin
						req.addr = n.ea;
					end else if (k == 4'd4) begin
						eidx = n.ea + {8'd0, n.x};
						if (eidx[15:8] != n.ea[15:8]) req.addr = n.pc;
						else begin
							req.addr = eidx; nstep = 4'd6;
						end
						n.ea = eidx;
					end else begin
						req.addr = n.ea;
					end
				end
				cpu65_pkg::C_IMPL: begin
					if (k == 4'd1) begin
						req.addr = n.pc;
					end else begin
						fin = 1'b1;
						case (n.op)
							8'hAA: begin n.x = n.a; n.p = cpu65_pkg::set_zn(n.p, n.a); end
							8'hA8: begin n.y = n.a; n.p = cpu65_pkg::set_zn(n.p, n.a); end
							8'hBA: begin n.x = n.sp; n.p = cpu65_pkg::set_zn(n.p, n.sp); end
							8'h8A: begin n.a = n.x; n.p = cpu65_pkg::set_zn(n.p, n.x); end
							8'h9A: n.sp = n.x;
							8'h98: begin n.a = n.y; n.p = cpu65_pkg::set_zn(n.p, n.y); end
							8'hE8: begin n.x = n.x + 8'd1; n.p = cpu65_pkg::set_zn(n.p, n.x); end
							8'hC8: begin n.y = n.y + 8'd1; n.p = cpu65_pkg::set_zn(n.p, n.y); end
							8'hCA: begin n.x = n.x - 8'd1; n.p = cpu65_pkg::set_zn(n.p, n.x); end
							8'h88: begin n.y = n.y - 8'd1; n.p = cpu65_pkg::set_zn(n.p, n.y); end
							8'h18: n.p[cpu65_pkg::F_C] = 1'b0;
							8'hD8: n.p[cpu65_pkg::F_D] = 1'b0;
							8'h58: n.p[cpu65_pkg::F_I] = 1'b0;
							8'hB8: n.p[cpu65_pkg::F_V] = 1'b0;
							8'h38: n.p[cpu65_pkg::F_C] = 1'b1;
							8'hF8: n.p[cpu65_pkg::F_D] = 1'b1;
							8'h78: n.p[cpu65_pkg::F_I] = 1'b1;
							default: n.p = n.p;
						endcase
					end
				end
				cpu65_pkg::C_PUSH: begin
					if (k == 4'd1) begin
						req.addr = n.pc;
					end else if (k == 4'd2) begin
						req.addr  = cpu65_pkg::STACK_PAGE | {8'd0, n.sp};
						req.wdata = (n.op == 8'h48) ? n.a : (n.p | cpu65_pkg::F_PUSH);
						req.kind  = cpu65_pkg::BUS_WRITE;
						n.sp      = n.sp - 8'd1;
					end else fin = 1'b1;
				end
				cpu65_pkg::C_PULL: begin
					if (k == 4'd1) begin
						req.addr = n.pc;
					end else if (k == 4'd2) begin
						req.addr = cpu65_pkg::STACK_PAGE | {8'd0, n.sp};
					end else if (k == 4'd3) begin
						n.sp = n.sp + 8'd1;
						req.addr = cpu65_pkg::STACK_PAGE | {8'd0, n.sp};
					end else begin
						fin = 1'b1;
						if (n.op == 8'h68) begin
							n.a = d; n.p = cpu65_pkg::set_zn(n.p, d);
						end else n.p = d;
					end
				end
				cpu65_pkg::C_JMP: begin
					if (k == 4'd1) begin
						req.addr = n.pc; n.pc = n.pc + 16'd1;
					end else if (k == 4'd2) begin
						n.dl = d; req.addr = n.pc; n.pc = n.pc + 16'd1;
					end else begin
						n.pc = {d, n.dl}; fin = 1'b1;
					end
				end
				cpu65_pkg::C_JIND: begin
					if (k == 4'd1) begin
						req.addr = n.pc; n.pc = n.pc + 16'd1;
					end else if (k == 4'd2) begin
						n.dl = d; req.addr = n.pc;
					end else if (k == 4'd3) begin
						n.ea = {d, n.dl}; req.addr = n.ea;
					end else if (k == 4'd4) begin
						if (n.op == 8'h7C) n.ea = n.ea + {8'd0, n.x};
						req.addr = n.ea;
					end else if (k == 4'd5) begin
						n.dl = d; n.ea = n.ea + 16'd1; req.addr = n.ea;
					end else begin
						n.pc = {d, n.dl}; fin = 1'b1;
					end
				end
				cpu65_pkg::C_JSR: begin
					if (k == 4'd1) begin
						req.addr = n.pc; n.pc = n.pc + 16'd1;
					end else if (k == 4'd2) begin
						n.dl = d; req.addr = cpu65_pkg::STACK_PAGE | {8'd0, n.sp};
					end else if (k == 4'd3 || k == 4'd4) begin
						req.addr  = cpu65_pkg::STACK_PAGE | {8'd0, n.sp};
						req.wdata = (k == 4'd3) ? n.pc[15:8] : n.pc[7:0];
						req.kind  = cpu65_pkg::BUS_WRITE;
						n.sp      = n.sp - 8'd1;
					end else if (k == 4'd5) begin
						req.addr = n.pc;
					end else begin
						n.pc = {d, n.dl}; fin = 1'b1;
					end
				end
				cpu65_pkg::C_RTS: begin
					if (k == 4'd1) begin
						req.addr = n.pc;
					end else if (k == 4'd2) begin
						req.addr = cpu65_pkg::STACK_PAGE | {8'd0, n.sp};
					end else if (k == 4'd3 || k == 4'd4) begin
						if (k == 4'd4) n.dl = d;
						n.sp = n.sp + 8'd1;
						req.addr = cpu65_pkg::STACK_PAGE | {8'd0, n.sp};
					end else if (k == 4'd5) begin
						n.pc = {d, n.dl}; req.addr = n.pc; n.pc = n.pc + 16'd1;
					end else fin = 1'b1;
				end
				cpu65_pkg::C_BRK: begin
					if (k == 4'd1) begin
						req.addr = n.pc; n.pc = n.pc + 16'd1;
					end else if (k >= 4'd2 && k <= 4'd4) begin
						req.addr = cpu65_pkg::STACK_PAGE | {8'd0, n.sp};
						req.kind = cpu65_pkg::BUS_WRITE;
						if (k == 4'd2) req.wdata = n.pc[15:8];
						else if (k == 4'd3) req.wdata = n.pc[7:0];
						else begin
							req.wdata = n.p | cpu65_pkg::F_PUSH;
							n.p[cpu65_pkg::F_I] = 1'b1;
							n.p[cpu65_pkg::F_D] = 1'b0;
						end
						n.sp = n.sp - 8'd1;
					end else if (k == 4'd5) begin
						req.addr = cpu65_pkg::VEC_BRK;
					end else if (k == 4'd6) begin
						n.dl = d; req.addr = cpu65_pkg::VEC_BRK + 16'd1;
					end else begin
						n.pc = {d, n.dl}; fin = 1'b1;
					end
				end
				cpu65_pkg::C_RTI: begin
					if (k == 4'd1) begin
						req.addr = n.pc;
					end else if (k == 4'd2) begin
						req.addr = cpu65_pkg::STACK_PAGE | {8'd0, n.sp};
					end else if (k >= 4'd3 && k <= 4'd5) begin
						if (k == 4'd4) n.p = d;
						if (k == 4'd5) n.dl = d;
						n.sp = n.sp + 8'd1;
						req.addr = cpu65_pkg::STACK_PAGE | {8'd0, n.sp};
					end else begin
						n.pc = {d, n.dl}; fin = 1'b1;
					end
				end
				cpu65_pkg::C_N5C: begin
					if (k <= 4'd2) begin
						req.addr = n.pc; n.pc = n.pc + 16'd1;
					end else if (k <= 4'd7) begin
						req.kind = cpu65_pkg::BUS_IDLE;
					end else fin = 1'b1;
				end
				default: fin = 1'b1;
			endcase
		end
		if (fin) begin
			req.addr  = n.pc;
			req.wdata = 8'd0;
			req.kind  = cpu65_pkg::BUS_READ;
			req.fetch = 1'b1;
			n.pc      = n.pc + 16'd1;
			nstep     = 4'd1;
		end
		n.step = nstep;
		nxt    = n;
	end

endmodule

// ===== hdl/cpu_65c02_subset_core_top.sv =====
// Top level of the 65C02-subset core: request register, state and result register.
// A tick request is taken into the input register, then its result into the state and result registers.
// Throughput: one tick request per cycle while the result is not stalled.
// A stalled result holds one further request in the input register.
// Reset (arst_n low) clears state; the first tick reads the reset vector low byte.
`timescale 1ns / 1ps
module cpu_65c02_subset_core_top (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [7:0]  read_data,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [15:0] bus_address,
	output logic [7:0]  bus_write_data,
	output logic [1:0]  bus_kind,
	output logic        opcode_fetch,
	output logic [7:0]  acc_value,
	output logic [7:0]  x_value,
	output logic [7:0]  y_value,
	output logic [7:0]  stack_value,
	output logic [7:0]  status_value,
	output logic [15:0] counter_value
);

	logic                  valid_s1;
	logic [7:0]            data_s1;
	logic                  advance;
	cpu65_pkg::cpu_state_t state_q;
	cpu65_pkg::cpu_state_t state_nxt;
	cpu65_pkg::bus_req_t   req;

	assign advance  = valid_s1 && (!out_valid || !out_stall);
	assign in_stall = valid_s1 && !advance;

	cpu65_exec u_exec (
		.cur (state_q),
		.d   (data_s1),
		.nxt (state_nxt),
		.req (req)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (!in_stall && in_valid) begin
			data_s1 <= read_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= '{step: cpu65_pkg::STEP_RESET_LO, default: '0};
			out_valid <= 1'b0;
		end else if (advance) begin
			state_q   <= state_nxt;
			out_valid <= 1'b1;
		end else if (!out_stall) begin
			out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			bus_address    <= req.addr;
			bus_write_data <= req.wdata;
			bus_kind       <= req.kind;
			opcode_fetch   <= req.fetch;
		end
	end

	assign acc_value     = state_q.a;
	assign x_value       = state_q.x;
	assign y_value       = state_q.y;
	assign stack_value   = state_q.sp;
	assign status_value  = state_q.p;
	assign counter_value = state_q.pc;

	a_adv_out: assert property (@(posedge clk) disable iff (!arst_n)
		advance |=> out_valid)
		else $error("stepped request gave no result");
	a_stall_full: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> valid_s1)
		else $error("stall raised with empty input register");
	a_idle_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && bus_kind == cpu65_pkg::BUS_IDLE) |->
		(bus_address == 16'd0 && bus_write_data == 8'd0))
		else $error("idle cycle carries address or data");
	a_fetch_read: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && opcode_fetch) |-> bus_kind == cpu65_pkg::BUS_READ)
		else $error("opcode fetch is not a read");

endmodule

// ===== tb/cpu65_tick_checker.sv =====
// Checker for the 65C02-subset core: predicts every tick's bus access and registers and compares.
`timescale 1ns / 1ps
module cpu65_tick_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	input  logic        in_stall,
	input  logic [7:0]  read_data,
	input  logic        out_valid,
	input  logic        out_stall,
	input  logic [15:0] bus_address,
	input  logic [7:0]  bus_write_data,
	input  logic [1:0]  bus_kind,
	input  logic        opcode_fetch,
	input  logic [7:0]  acc_value,
	input  logic [7:0]  x_value,
	input  logic [7:0]  y_value,
	input  logic [7:0]  stack_value,
	input  logic [7:0]  status_value,
	input  logic [15:0] counter_value,
	output int          fail_count,
	output int          pending_count
);

	localparam logic [7:0] OP_BRK = 8'h00, OP_PHP = 8'h08, OP_CLC = 8'h18, OP_JSR = 8'h20;
	localparam logic [7:0] OP_PLP = 8'h28, OP_SEC = 8'h38, OP_RTI = 8'h40, OP_NOP_ZP = 8'h44;
	localparam logic [7:0] OP_PHA = 8'h48, OP_JMP = 8'h4C, OP_NOP_ZPX0 = 8'h54, OP_CLI = 8'h58;
	localparam logic [7:0] OP_NOP_5C = 8'h5C, OP_RTS = 8'h60, OP_PLA = 8'h68, OP_JMP_IND = 8'h6C;
	localparam logic [7:0] OP_SEI = 8'h78, OP_JMP_INDX = 8'h7C, OP_DEY = 8'h88, OP_TXA = 8'h8A;
	localparam logic [7:0] OP_TYA = 8'h98, OP_TXS = 8'h9A, OP_LDX_IMM = 8'hA2, OP_TAY = 8'hA8;
	localparam logic [7:0] OP_TAX = 8'hAA, OP_CLV = 8'hB8, OP_TSX = 8'hBA, OP_INY = 8'hC8;
	localparam logic [7:0] OP_DEX = 8'hCA, OP_NOP_ZPX1 = 8'hD4, OP_CLD = 8'hD8;
	localparam logic [7:0] OP_NOP_ABSX0 = 8'hDC, OP_INX = 8'hE8, OP_NOP = 8'hEA;
	localparam logic [7:0] OP_NOP_ZPX2 = 8'hF4, OP_SED = 8'hF8, OP_NOP_ABSX1 = 8'hFC;
	localparam logic [7:0] OP_DEC_ZP = 8'hC6, OP_DEC_ZPX = 8'hD6, OP_DEC_ABS = 8'hCE;
	localparam logic [7:0] OP_DEC_ABSX = 8'hDE, OP_INC_ZP = 8'hE6, OP_INC_ZPX = 8'hF6;
	localparam logic [7:0] OP_INC_ABS = 8'hEE, OP_INC_ABSX = 8'hFE;
	localparam logic [7:0] OP_NOP2_0 = 8'h02, OP_NOP2_1 = 8'h22, OP_NOP2_2 = 8'h42;
	localparam logic [7:0] OP_NOP2_3 = 8'h62, OP_NOP2_4 = 8'h82, OP_NOP2_5 = 8'hC2;
	localparam logic [7:0] OP_NOP2_6 = 8'hE2;
	localparam logic [6:0] ALU_IMM = 7'h69, ALU_ZP = 7'h65, ALU_ZPX = 7'h75, ALU_ABS = 7'h6D;
	localparam logic [6:0] ALU_ABSX = 7'h7D, ALU_ABSY = 7'h79, ALU_INDX = 7'h61;
	localparam logic [6:0] ALU_INDY = 7'h71, ALU_ZIND = 7'h72;
	localparam int RMW_BUSY = 0, RMW_MODIFY = 1, RMW_DONE = 2;

	typedef struct packed {
		logic [15:0] addr;
		logic [7:0]  wdata;
		logic [1:0]  kind;
		logic        fetch;
		logic [7:0]  a;
		logic [7:0]  x;
		logic [7:0]  y;
		logic [7:0]  sp;
		logic [7:0]  p;
		logic [15:0] pc;
	} tick_result_t;

	tick_result_t expected_ticks[$];

	logic [15:0]          pc, ea, o_addr;
	logic [7:0]           sp, acc, ix, iy, ps, opc, dl, o_wdata;
	logic [3:0]           stp, nstep;
	cpu65_pkg::bus_kind_t o_kind;

	function automatic void rd(input logic [15:0] a);
		o_addr = a; o_wdata = 8'd0; o_kind = cpu65_pkg::BUS_READ;
	endfunction

	function automatic void wr(input logic [15:0] a, input logic [7:0] v);
		o_addr = a; o_wdata = v; o_kind = cpu65_pkg::BUS_WRITE;
	endfunction

	function automatic void rd_pc();
		rd(pc);
		pc = pc + 16'd1;
	endfunction

	function automatic void push_byte(input logic [7:0] v);
		wr(cpu65_pkg::STACK_PAGE | {8'd0, sp}, v);
		sp = sp - 8'd1;
	endfunction

	function automatic void pull_rd();
		sp = sp + 8'd1;
		rd(cpu65_pkg::STACK_PAGE | {8'd0, sp});
	endfunction

	function automatic void zn(input logic [7:0] v);
		ps = {v[7], ps[6:2], v == 8'd0, ps[0]};
	endfunction

	function automatic void add_byte(input logic [7:0] b);
		logic [8:0] s;
		logic [7:0] r;
		s = {1'b0, acc} + {1'b0, b} + {8'd0, ps[cpu65_pkg::F_C]};
		r = s[7:0];
		zn(r);
		ps[cpu65_pkg::F_C] = s[8];
		ps[cpu65_pkg::F_V] = ((acc ^ r) & (b ^ r) & 8'h80) != 8'd0;
		acc = r;
	endfunction

	function automatic void indexed(input logic [15:0] base, input logic [7:0] idx,
			input logic [3:0] skip);
		ea = base + {8'd0, idx};
		if (ea[15:8] != base[15:8]) begin
			rd(pc);
			pc = pc + 16'd1;
		end else begin
			pc = pc + 16'd1;
			rd(ea);
			nstep = skip;
		end
	endfunction

	function automatic logic [15:0] zp_next(input logic [7:0] idx);
		logic [7:0] z;
		z = ea[7:0] + idx;
		return {8'd0, z};
	endfunction

	function automatic bit load_operand(input cpu65_pkg::mode_t m, input logic [3:0] k,
			input logic [7:0] d);
		if (k == 1) begin
			if (m == cpu65_pkg::M_INDY) rd(pc);
			else rd_pc();
			return 0;
		end
		case (m)
			cpu65_pkg::M_IMM: return 1;
			cpu65_pkg::M_ZP: begin
				if (k == 2) begin ea = {8'd0, d}; rd(ea); return 0; end
				return 1;
			end
			cpu65_pkg::M_ZPX: begin
				if (k == 2) begin ea = {8'd0, d}; rd(ea); return 0; end
				if (k == 3) begin ea = zp_next(ix); rd(ea); return 0; end
				return 1;
			end
			cpu65_pkg::M_ABS: begin
				if (k == 2) begin dl = d; rd_pc(); return 0; end
				if (k == 3) begin ea = {d, dl}; rd(ea); return 0; end
				return 1;
			end
			cpu65_pkg::M_ABSX, cpu65_pkg::M_ABSY: begin
				if (k == 2) begin dl = d; rd(pc); return 0; end
				if (k == 3) begin
					indexed({d, dl}, m == cpu65_pkg::M_ABSX ? ix : iy, 4'd5);
					return 0;
				end
				if (k == 4) begin rd(ea); return 0; end
				return 1;
			end
			cpu65_pkg::M_ABSX_FLAT: begin
				if (k == 2) begin dl = d; rd(pc); return 0; end
				if (k == 3) begin
					ea = {d, dl} + {8'd0, ix};
					pc = pc + 16'd1;
					rd(ea);
					return 0;
				end
				return 1;
			end
			cpu65_pkg::M_INDX: begin
				if (k == 2) begin ea = {8'd0, d}; rd(ea); return 0; end
				if (k == 3) begin ea = zp_next(ix); rd(ea); return 0; end
				if (k == 4) begin dl = d; rd(zp_next(8'd1)); return 0; end
				if (k == 5) begin ea = {d, dl}; rd(ea); return 0; end
				return 1;
			end
			cpu65_pkg::M_INDY: begin
				if (k == 2) begin ea = {8'd0, d}; rd(ea); return 0; end
				if (k == 3) begin dl = d; rd(zp_next(8'd1)); return 0; end
				if (k == 4) begin indexed({d, dl}, iy, 4'd6); return 0; end
				if (k == 5) begin rd(ea); return 0; end
				return 1;
			end
			default: begin
				if (k == 2) begin ea = {8'd0, d}; rd(ea); return 0; end
				if (k == 3) begin dl = d; rd(zp_next(8'd1)); return 0; end
				if (k == 4) begin ea = {d, dl}; rd(ea); return 0; end
				return 1;
			end
		endcase
	endfunction

	function automatic int modify_step(input cpu65_pkg::mode_t m, input logic [3:0] k,
			input logic [7:0] d);
		int last;
		logic [15:0] n;
		last = (m == cpu65_pkg::M_ZP) ? 4 : (m == cpu65_pkg::M_ABSX) ? 6 : 5;
		if (k == last) return RMW_MODIFY;
		if (k > last) return RMW_DONE;
		if (k == 1) begin rd_pc(); return RMW_BUSY; end
		if (m == cpu65_pkg::M_ZP || m == cpu65_pkg::M_ZPX) begin
			if (k == 2) begin ea = {8'd0, d}; rd(ea); return RMW_BUSY; end
			if (k == 3) begin rd(ea); return RMW_BUSY; end
			ea = zp_next(ix);
			rd(ea);
			return RMW_BUSY;
		end
		if (k == 2) begin dl = d; rd_pc(); return RMW_BUSY; end
		if (k == 3) begin ea = {d, dl}; rd(ea); return RMW_BUSY; end
		if (m == cpu65_pkg::M_ABS) begin rd(ea); return RMW_BUSY; end
		if (k == 4) begin
			n = ea + {8'd0, ix};
			if (n[15:8] != ea[15:8]) rd(pc);
			else begin
				rd(n);
				nstep = 4'd6;
			end
			ea = n;
			return RMW_BUSY;
		end
		rd(ea);
		return RMW_BUSY;
	endfunction

	function automatic bit run_op(input logic [3:0] k, input logic [7:0] d);
		cpu65_pkg::mode_t m;
		int r;
		logic [7:0] v;
		bit alu;
		alu = 1;
		case (opc[6:0])
			ALU_IMM: m = cpu65_pkg::M_IMM;
			ALU_ZP: m = cpu65_pkg::M_ZP;
			ALU_ZPX: m = cpu65_pkg::M_ZPX;
			ALU_ABS: m = cpu65_pkg::M_ABS;
			ALU_ABSX: m = cpu65_pkg::M_ABSX;
			ALU_ABSY: m = cpu65_pkg::M_ABSY;
			ALU_INDX: m = cpu65_pkg::M_INDX;
			ALU_INDY: m = cpu65_pkg::M_INDY;
			ALU_ZIND: m = cpu65_pkg::M_ZIND;
			default: alu = 0;
		endcase
		if (alu) begin
			if (!load_operand(m, k, d)) return 0;
			add_byte(opc[7] ? ~d : d);
			return 1;
		end
		case (opc)
			OP_INC_ZP, OP_DEC_ZP, OP_INC_ZPX, OP_DEC_ZPX,
			OP_INC_ABS, OP_DEC_ABS, OP_INC_ABSX, OP_DEC_ABSX: begin
				case (opc)
					OP_INC_ZP, OP_DEC_ZP: m = cpu65_pkg::M_ZP;
					OP_INC_ZPX, OP_DEC_ZPX: m = cpu65_pkg::M_ZPX;
					OP_INC_ABS, OP_DEC_ABS: m = cpu65_pkg::M_ABS;
					default: m = cpu65_pkg::M_ABSX;
				endcase
				r = modify_step(m, k, d);
				if (r == RMW_BUSY) return 0;
				if (r == RMW_MODIFY) begin
					v = opc[5] ? d + 8'd1 : d - 8'd1;
					zn(v);
					wr(ea, v);
					return 0;
				end
				return 1;
			end
			OP_NOP, OP_TAX, OP_TAY, OP_TSX, OP_TXA, OP_TXS, OP_TYA, OP_INX, OP_INY,
			OP_DEX, OP_DEY, OP_CLC, OP_CLD, OP_CLI, OP_CLV, OP_SEC, OP_SED, OP_SEI: begin
				if (k == 1) begin rd(pc); return 0; end
				case (opc)
					OP_TAX: begin ix = acc; zn(ix); end
					OP_TAY: begin iy = acc; zn(iy); end
					OP_TSX: begin ix = sp; zn(ix); end
					OP_TXA: begin acc = ix; zn(acc); end
					OP_TXS: sp = ix;
					OP_TYA: begin acc = iy; zn(acc); end
					OP_INX: begin ix = ix + 8'd1; zn(ix); end
					OP_INY: begin iy = iy + 8'd1; zn(iy); end
					OP_DEX: begin ix = ix - 8'd1; zn(ix); end
					OP_DEY: begin iy = iy - 8'd1; zn(iy); end
					OP_CLC: ps[cpu65_pkg::F_C] = 1'b0;
					OP_CLD: ps[cpu65_pkg::F_D] = 1'b0;
					OP_CLI: ps[cpu65_pkg::F_I] = 1'b0;
					OP_CLV: ps[cpu65_pkg::F_V] = 1'b0;
					OP_SEC: ps[cpu65_pkg::F_C] = 1'b1;
					OP_SED: ps[cpu65_pkg::F_D] = 1'b1;
					OP_SEI: ps[cpu65_pkg::F_I] = 1'b1;
					default: ;
				endcase
				return 1;
			end
			OP_LDX_IMM: begin
				if (!load_operand(cpu65_pkg::M_IMM, k, d)) return 0;
				ix = d;
				zn(d);
				return 1;
			end
			OP_NOP2_0, OP_NOP2_1, OP_NOP2_2, OP_NOP2_3, OP_NOP2_4, OP_NOP2_5, OP_NOP2_6:
				return load_operand(cpu65_pkg::M_IMM, k, d);
			OP_NOP_ZP: return load_operand(cpu65_pkg::M_ZP, k, d);
			OP_NOP_ZPX0, OP_NOP_ZPX1, OP_NOP_ZPX2: return load_operand(cpu65_pkg::M_ZPX, k, d);
			OP_NOP_ABSX0, OP_NOP_ABSX1: return load_operand(cpu65_pkg::M_ABSX_FLAT, k, d);
			OP_NOP_5C: begin
				if (k <= 2) begin rd_pc(); return 0; end
				if (k <= 7) begin
					o_addr = 16'd0; o_wdata = 8'd0; o_kind = cpu65_pkg::BUS_IDLE;
					return 0;
				end
				return 1;
			end
			OP_PHA, OP_PHP: begin
				if (k == 1) begin rd(pc); return 0; end
				if (k == 2) begin
					push_byte(opc == OP_PHA ? acc : ps | cpu65_pkg::F_PUSH);
					return 0;
				end
				return 1;
			end
			OP_PLA, OP_PLP: begin
				if (k == 1) begin rd(pc); return 0; end
				if (k == 2) begin rd(cpu65_pkg::STACK_PAGE | {8'd0, sp}); return 0; end
				if (k == 3) begin pull_rd(); return 0; end
				if (opc == OP_PLA) begin acc = d; zn(d); end
				else ps = d;
				return 1;
			end
			OP_JMP: begin
				if (k == 1) begin rd_pc(); return 0; end
				if (k == 2) begin dl = d; rd_pc(); return 0; end
				pc = {d, dl};
				return 1;
			end
			OP_JMP_IND, OP_JMP_INDX: begin
				if (k == 1) begin rd_pc(); return 0; end
				if (k == 2) begin dl = d; rd(pc); return 0; end
				if (k == 3) begin ea = {d, dl}; rd(ea); return 0; end
				if (k == 4) begin
					if (opc == OP_JMP_INDX) ea = ea + {8'd0, ix};
					rd(ea);
					return 0;
				end
				if (k == 5) begin dl = d; ea = ea + 16'd1; rd(ea); return 0; end
				pc = {d, dl};
				return 1;
			end
			OP_JSR: begin
				if (k == 1) begin rd_pc(); return 0; end
				if (k == 2) begin dl = d; rd(cpu65_pkg::STACK_PAGE | {8'd0, sp}); return 0; end
				if (k == 3) begin push_byte(pc[15:8]); return 0; end
				if (k == 4) begin push_byte(pc[7:0]); return 0; end
				if (k == 5) begin rd(pc); return 0; end
				pc = {d, dl};
				return 1;
			end
			OP_RTS: begin
				if (k == 1) begin rd(pc); return 0; end
				if (k == 2) begin rd(cpu65_pkg::STACK_PAGE | {8'd0, sp}); return 0; end
				if (k == 3) begin pull_rd(); return 0; end
				if (k == 4) begin dl = d; pull_rd(); return 0; end
				if (k == 5) begin pc = {d, dl}; rd_pc(); return 0; end
				return 1;
			end
			OP_BRK: begin
				if (k == 1) begin rd_pc(); return 0; end
				if (k == 2) begin push_byte(pc[15:8]); return 0; end
				if (k == 3) begin push_byte(pc[7:0]); return 0; end
				if (k == 4) begin
					push_byte(ps | cpu65_pkg::F_PUSH);
					ps[cpu65_pkg::F_I] = 1'b1;
					ps[cpu65_pkg::F_D] = 1'b0;
					return 0;
				end
				if (k == 5) begin rd(cpu65_pkg::VEC_BRK); return 0; end
				if (k == 6) begin dl = d; rd(cpu65_pkg::VEC_BRK + 16'd1); return 0; end
				pc = {d, dl};
				return 1;
			end
			OP_RTI: begin
				if (k == 1) begin rd(pc); return 0; end
				if (k == 2) begin rd(cpu65_pkg::STACK_PAGE | {8'd0, sp}); return 0; end
				if (k == 3) begin pull_rd(); return 0; end
				if (k == 4) begin ps = d; pull_rd(); return 0; end
				if (k == 5) begin dl = d; pull_rd(); return 0; end
				pc = {d, dl};
				return 1;
			end
			default: return 1;
		endcase
	endfunction

	function automatic tick_result_t step_core(input logic [7:0] d);
		logic [3:0] k;
		bit fetch;
		tick_result_t t;
		k = stp;
		fetch = 0;
		nstep = k + 4'd1;
		if (k == cpu65_pkg::STEP_RESET_LO) rd(cpu65_pkg::VEC_RESET);
		else if (k == cpu65_pkg::STEP_RESET_HI) begin
			dl = d;
			rd(cpu65_pkg::VEC_RESET + 16'd1);
		end else if (k == cpu65_pkg::STEP_RESET_GO) begin
			pc = {d, dl};
			fetch = 1;
		end else begin
			if (k <= 1) begin
				k = 4'd1;
				opc = d;
				nstep = 4'd2;
			end
			fetch = run_op(k, d);
		end
		if (fetch) begin
			rd_pc();
			nstep = 4'd1;
		end
		stp = nstep;
		t = '{o_addr, o_wdata, o_kind, fetch, acc, ix, iy, sp, ps, pc};
		return t;
	endfunction

	task automatic check_field(input string name, input int want, input int got);
		if (want != got) begin
			$error("%s expected %0h actual %0h", name, want, got);
			fail_count++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		tick_result_t t;
		if (!arst_n) begin
			pc = 16'd0; sp = 8'd0; acc = 8'd0; ix = 8'd0; iy = 8'd0; ps = 8'd0;
			opc = 8'd0; stp = cpu65_pkg::STEP_RESET_LO; ea = 16'd0; dl = 8'd0;
			expected_ticks.delete();
			fail_count = 0;
			pending_count <= 0;
		end else begin
			if (out_valid && !out_stall) begin
				if (expected_ticks.size() == 0) begin
					$error("result with no request waiting");
					fail_count++;
				end else begin
					t = expected_ticks.pop_front();
					check_field("bus_address", t.addr, bus_address);
					check_field("bus_write_data", t.wdata, bus_write_data);
					check_field("bus_kind", t.kind, bus_kind);
					check_field("opcode_fetch", t.fetch, opcode_fetch);
					check_field("acc_value", t.a, acc_value);
					check_field("x_value", t.x, x_value);
					check_field("y_value", t.y, y_value);
					check_field("stack_value", t.sp, stack_value);
					check_field("status_value", t.p, status_value);
					check_field("counter_value", t.pc, counter_value);
				end
			end
			if (in_valid && !in_stall) expected_ticks.push_back(step_core(read_data));
			pending_count <= expected_ticks.size();
		end
	end

endmodule

// ===== tb/tb_cpu_65c02_subset_core_top.sv =====
// Testbench top for the 65C02-subset core: drives tick requests, stalls results, gives the verdict.
`timescale 1ns / 1ps
module tb_cpu_65c02_subset_core_top;

	localparam int NUM_RANDOM = 1880;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_stall;
	logic [7:0]  read_data = 8'd0;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic [15:0] bus_address;
	logic [7:0]  bus_write_data;
	logic [1:0]  bus_kind;
	logic        opcode_fetch;
	logic [7:0]  acc_value, x_value, y_value, stack_value, status_value;
	logic [15:0] counter_value;
	logic        in_taken = 1'b0;
	logic        calm = 1'b0;
	int          fail_count, pending_count;

	// implemented opcodes, weighted into the random stream so fetches decode real work
	logic [7:0] opcode_pool [0:47] = '{
		8'h69, 8'h65, 8'h75, 8'h6D, 8'h7D, 8'h79, 8'h61, 8'h71, 8'h72,
		8'hE9, 8'hE5, 8'hF5, 8'hED, 8'hFD, 8'hF9, 8'hE1, 8'hF1, 8'hF2,
		8'hE6, 8'hC6, 8'hF6, 8'hD6, 8'hEE, 8'hCE, 8'hFE, 8'hDE,
		8'hAA, 8'hA8, 8'hBA, 8'h8A, 8'h9A, 8'h98, 8'hE8, 8'hC8, 8'hCA, 8'h88,
		8'h48, 8'h08, 8'h68, 8'h28, 8'hA2, 8'h4C, 8'h6C, 8'h7C, 8'h20, 8'h60,
		8'h00, 8'h40
	};

	logic [7:0] directed [0:24] = '{
		8'h00, 8'hFF, 8'hFF, 8'hA2, 8'h80, 8'h9A, 8'h00, 8'h69, 8'h7F, 8'hE9,
		8'hFF, 8'h38, 8'h00, 8'h08, 8'h00, 8'h28, 8'h00, 8'hFF, 8'hFF, 8'h5C,
		8'h12, 8'h34, 8'hD4, 8'h00, 8'hFC
	};

	always #1 clk = ~clk;

	always @(posedge clk) in_taken <= in_valid && !in_stall;

	cpu_65c02_subset_core_top DUT (.*);

	cpu65_tick_checker u_checker (.*);

	task automatic offer(input logic [7:0] b);
		in_valid <= 1'b1;
		read_data <= b;
		do @(negedge clk); while (!in_taken);
	endtask

	task automatic maybe_gap();
		if (!calm && $urandom_range(0, 9) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 16)) @(negedge clk);
		end
	endtask

	initial begin
		int hold;
		bit stalling;
		int cyc;
		hold = 0;
		stalling = 0;
		cyc = 0;
		wait (arst_n);
		forever begin
			@(negedge clk);
			cyc++;
			if (cyc >= 600 && cyc < 900) out_stall <= 1'b1;
			else if (calm) out_stall <= 1'b0;
			else begin
				if (hold == 0) begin
					stalling = ($urandom_range(0, 3) == 0);
					hold = $urandom_range(1, 16);
				end
				hold--;
				out_stall <= stalling;
			end
		end
	end

	initial begin
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);
		foreach (directed[i]) begin
			maybe_gap();
			offer(directed[i]);
		end
		for (int i = 0; i < NUM_RANDOM; i++) begin
			if (i >= NUM_RANDOM - 150) calm = 1'b1;
			if (i == 1000) begin
				in_valid <= 1'b0;
				do @(negedge clk); while (pending_count != 0);
			end
			maybe_gap();
			if ($urandom_range(0, 1) == 0) offer(opcode_pool[$urandom_range(0, 47)]);
			else offer(8'($urandom_range(0, 255)));
		end
		in_valid <= 1'b0;
		do @(negedge clk); while (pending_count != 0);
		repeat (10) @(negedge clk);
		if (fail_count == 0) $display("SUCCESS");
		else $display("FAILURE");
		$finish;
	end

	initial begin
		#2000000;
		$display("FAILURE");
		$finish;
	end

endmodule
